FILE: sv/sle_pkg.sv
`timescale 1ns / 1ps

package sle_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 6;
  localparam int LEN_W        = 6;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_FIND   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_code_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BAD_POS = 2'd2,
    ST_RSVD    = 2'd3
  } status_t;

  typedef struct packed {
    req_code_t                 req_type;
    logic signed [DATA_W-1:0]  item_value;
    logic        [POS_W-1:0]   item_position;
  } req_t;

  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  removed_value;
    logic                      found;
    logic        [LEN_W-1:0]   list_length;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // latch request, clear result
    logic exec;     // first step of the request
    logic capture;  // take removed word from read data
    logic walk;     // one step of shift or scan
    logic finish;   // shift done, drop one entry
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    req_code_t req_type;
    logic      bad_pos;
    logic      walk_done;
  } sts_t;

endpackage

FILE: sv/sle_ctrl.sv
`timescale 1ns / 1ps

module sle_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output logic          done_strobe,
  output sle_pkg::cmd_t cmd,
  input  sle_pkg::sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DEL_CAP,
    S_SHIFT,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   strobe_r, strobe_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        unique case (sts.req_type)
          sle_pkg::REQ_DELETE: state_nxt = sts.bad_pos ? S_DONE : S_DEL_CAP;
          sle_pkg::REQ_FIND:   state_nxt = S_SCAN;
          default:             state_nxt = S_DONE;
        endcase
      end
      S_DEL_CAP: begin
        cmd.capture = 1'b1;
        state_nxt   = S_SHIFT;
      end
      S_SHIFT: begin
        if (sts.walk_done) begin
          cmd.finish = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          cmd.walk = 1'b1;
        end
      end
      S_SCAN: begin
        if (sts.walk_done) begin
          state_nxt = S_DONE;
        end else begin
          cmd.walk = 1'b1;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    busy_nxt   = (state_nxt != S_IDLE);
    strobe_nxt = (state_nxt == S_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      busy_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      busy_r   <= busy_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  assign busy        = busy_r;
  assign done_strobe = strobe_r;

endmodule

FILE: sv/sle_dp.sv
`timescale 1ns / 1ps

module sle_dp #(
  parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  sle_pkg::req_t in_data,
  input  sle_pkg::cmd_t cmd,
  output sle_pkg::sts_t sts,
  output sle_pkg::rsp_t out_data
);

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CW    = (CNT_W > sle_pkg::POS_W) ? CNT_W : sle_pkg::POS_W;

  logic [sle_pkg::DATA_W-1:0] mem [CAPACITY];

  sle_pkg::req_t              req_r, req_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [CNT_W-1:0]           idx_r, idx_nxt;
  logic [AW-1:0]              wr_idx_r, wr_idx_nxt;
  logic                       pend_r, pend_nxt;
  logic [sle_pkg::DATA_W-1:0] rdata_r;
  sle_pkg::status_t           status_r, status_nxt;
  logic [sle_pkg::DATA_W-1:0] removed_r, removed_nxt;
  logic                       found_r, found_nxt;

  logic                       mem_we, mem_re;
  logic [AW-1:0]              mem_waddr, mem_raddr;
  logic [sle_pkg::DATA_W-1:0] mem_wdata;

  logic [CW-1:0] pos_x, cnt_x;
  logic          full, bad_pos, rd_go, shifting;

  assign pos_x    = CW'(req_r.item_position);
  assign cnt_x    = CW'(cnt_r);
  assign full     = (cnt_r == CNT_W'(CAPACITY));
  assign bad_pos  = (pos_x == '0) || (pos_x > cnt_x);
  assign rd_go    = (idx_r < cnt_r);
  assign shifting = (req_r.req_type == sle_pkg::REQ_DELETE);

  always_comb begin
    req_nxt     = req_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    wr_idx_nxt  = wr_idx_r;
    pend_nxt    = pend_r;
    status_nxt  = status_r;
    removed_nxt = removed_r;
    found_nxt   = found_r;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = cnt_r[AW-1:0];
    mem_wdata   = req_r.item_value;
    mem_raddr   = idx_r[AW-1:0];

    if (cmd.load) begin
      req_nxt     = in_data;
      status_nxt  = sle_pkg::ST_OK;
      removed_nxt = '0;
      found_nxt   = 1'b0;
    end

    if (cmd.exec) begin
      case (req_r.req_type)
        sle_pkg::REQ_APPEND: begin
          if (full) begin
            status_nxt = sle_pkg::ST_FULL;
          end else begin
            mem_we  = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        sle_pkg::REQ_DELETE: begin
          if (bad_pos) begin
            status_nxt = sle_pkg::ST_BAD_POS;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = AW'(pos_x - 1'b1);
            idx_nxt   = CNT_W'(pos_x);
            pend_nxt  = 1'b0;
          end
        end
        sle_pkg::REQ_FIND: begin
          idx_nxt  = '0;
          pend_nxt = 1'b0;
        end
        default: begin
          cnt_nxt = '0;
        end
      endcase
    end

    if (cmd.capture) begin
      removed_nxt = rdata_r;
    end

    // read idx, then on the next step write it one slot down (delete)
    // or compare it against the key (find)
    if (cmd.walk) begin
      mem_re     = rd_go;
      idx_nxt    = rd_go ? idx_r + 1'b1 : idx_r;
      wr_idx_nxt = AW'(idx_r - 1'b1);
      pend_nxt   = rd_go;
      if (pend_r) begin
        if (shifting) begin
          mem_we    = 1'b1;
          mem_waddr = wr_idx_r;
          mem_wdata = rdata_r;
        end else if (rdata_r == req_r.item_value) begin
          found_nxt = 1'b1;
        end
      end
    end

    if (cmd.finish) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    idx_r     <= idx_nxt;
    wr_idx_r  <= wr_idx_nxt;
    status_r  <= status_nxt;
    removed_r <= removed_nxt;
    found_r   <= found_nxt;
  end

  assign sts.req_type  = req_r.req_type;
  assign sts.bad_pos   = bad_pos;
  assign sts.walk_done = !rd_go && !pend_r;

  assign out_data.status        = status_r;
  assign out_data.removed_value = removed_r;
  assign out_data.found         = found_r;
  assign out_data.list_length   = sle_pkg::LEN_W'(cnt_r);

endmodule

FILE: sv/sequential_list_engine.sv
`timescale 1ns / 1ps
// channel  ports                       handshake
// -------  --------------------------  ---------------------------------------
// input    start, busy, in_data        word taken at edge with start & !busy
// result   out_strobe, out_data        word valid for the one strobe cycle
//
// States per word, n = entries held, p = delete position:
//   append, clear, rejected delete: exec, then done
//   find: exec, scan n entries, done; delete: exec, capture, shift n - p, done
// Shift and scan walk the entry RAM through its single registered read port,
// one entry per cycle; in a shift, a write trails each read on the write port.
// Reset (rst_n low, synchronous) empties the list; entry RAM is not cleared.
// busy stays high from accept through the strobe cycle; results cannot stall.

module sequential_list_engine #(
  parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  sle_pkg::req_t in_data,
  output logic          out_strobe,
  output sle_pkg::rsp_t out_data
);

  sle_pkg::cmd_t cmd;   // sequencing commands to the datapath
  sle_pkg::sts_t sts;   // request kind and loop status back

  sle_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done_strobe (out_strobe),
    .cmd         (cmd),
    .sts         (sts)
  );

  // list RAM, length counter, walk pointers and result registers
  sle_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

FILE: sv/sle_checker.sv
`timescale 1ns / 1ps

module sle_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input sle_pkg::rsp_t out_data,
  input logic          out_strobe
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accept did not raise busy");

  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("result strobe longer than a cycle");

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy) else $error("result without a word in flight");

  a_strobe_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !busy) else $error("busy held after result");

  a_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.found |->
      out_data.status == sle_pkg::ST_OK && out_data.removed_value == '0)
    else $error("find result carries delete fields");

endmodule

bind sequential_list_engine sle_checker u_sle_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_data   (out_data),
  .out_strobe (out_strobe)
);
